### rtl/csst_pkg.sv
`default_nettype none
package csst_pkg;

    localparam int BUCKET_COUNT     = 1024;
    localparam int SLOTS_PER_BUCKET = 4;
    localparam int MAX_KICKS        = 512;

    localparam int BUCKET_BITS = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
    localparam int SLOT_BITS   = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
    localparam int KICK_BITS   = (MAX_KICKS > 1) ? $clog2(MAX_KICKS) : 1;

    localparam logic [12:0] COUNT_MAX = 13'd8191;
    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_QUERY  = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_CLEAR  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        STAT_ADDED     = 3'd0,
        STAT_IN_ORDER  = 3'd1,
        STAT_OUT_ORDER = 3'd2,
        STAT_CNT_BIG   = 3'd3,
        STAT_DUPLICATE = 3'd4,
        STAT_GAP       = 3'd5,
        STAT_FULL      = 3'd6
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_HASH,
        S_RD1,
        S_RD2,
        S_EVAL,
        S_SWAP,
        S_KHASH,
        S_KRD,
        S_KEVAL,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [7:0]  mask;
        logic [7:0]  lc;
        logic [15:0] fp;
    } slot_t;

    typedef slot_t [SLOTS_PER_BUCKET-1:0] row_t;

    typedef struct packed {
        logic                 hit;
        logic [SLOT_BITS-1:0] idx;
    } hit_t;

    typedef struct packed {
        status_t status;
        slot_t   slot;
    } merge_t;

    // first slot holding fp (fp == 0 searches for an empty slot)
    function automatic hit_t find_fp(row_t row, logic [15:0] fp);
        hit_t r;
        r = '0;
        for (int s = SLOTS_PER_BUCKET - 1; s >= 0; s--) begin
            if (row[s].fp == fp) begin
                r.hit = 1'b1;
                r.idx = SLOT_BITS'(s);
            end
        end
        return r;
    endfunction

    // fold a counter into a matching entry
    function automatic merge_t merge_fn(slot_t s, logic [7:0] cnt);
        merge_t      r;
        logic [8:0]  diff;
        logic [7:0]  m1;
        logic [3:0]  t;
        logic        run;
        r.slot = s;
        diff = {1'b0, cnt} - {1'b0, s.lc};
        m1 = s.mask >> 1;
        t = '0;
        run = 1'b1;
        for (int b = 0; b < 8; b++) begin
            if (run && m1[b]) begin
                t = t + 4'd1;
            end else begin
                run = 1'b0;
            end
        end
        if (diff == 9'd1) begin
            r.status = STAT_IN_ORDER;
            r.slot.lc = cnt + {4'd0, t};
            r.slot.mask = m1 >> t;
        end else if (diff[8] || diff == 9'd0) begin
            r.status = STAT_DUPLICATE;
        end else if (diff <= 9'd8) begin
            r.status = STAT_OUT_ORDER;
            r.slot.mask = s.mask | (8'd1 << (diff[3:0] - 4'd1));
        end else begin
            r.status = STAT_GAP;
            r.slot.lc = cnt;
            r.slot.mask = '0;
        end
        return r;
    endfunction

    function automatic logic [15:0] lfsr_step(logic [15:0] v);
        return v[0] ? ((v >> 1) ^ LFSR_TAPS) : (v >> 1);
    endfunction

endpackage
`default_nettype wire

### rtl/csst_fp_hash.sv
`default_nettype none
// 32-bit hash of a fingerprint; four multiply steps on one shared multiplier.
module csst_fp_hash (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [15:0] fp,
    output logic             done,
    output logic [31:0]      hash
);

    localparam logic [31:0] PRIME1 = 32'd3266489917;
    localparam logic [31:0] PRIME2 = 32'd668265263;
    localparam logic [31:0] PRIME3 = 32'd2246822519;
    localparam logic [31:0] SEED_C = 32'd374761398;

    logic [2:0]  step_reg, step_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] op_a, op_b, prod, addend, rot;

    assign rot  = {acc_reg[14:0], acc_reg[31:15]};
    assign prod = op_a * op_b;

    always_comb begin
        op_a = acc_reg;
        op_b = PRIME1;
        addend = '0;
        step_next = step_reg;
        unique case (step_reg)
            3'd0: begin
                op_a = {16'd0, fp};
                addend = SEED_C;
                if (start) begin
                    step_next = 3'd1;
                end
            end
            3'd1: begin
                op_a = rot;
                op_b = PRIME2;
                step_next = 3'd2;
            end
            3'd2: begin
                op_a = acc_reg ^ (acc_reg >> 15);
                op_b = PRIME3;
                step_next = 3'd3;
            end
            3'd3: begin
                op_a = acc_reg ^ (acc_reg >> 13);
                step_next = 3'd4;
            end
            default: begin
                step_next = 3'd0;
            end
        endcase
        acc_next = (step_reg == 3'd4) ? acc_reg : prod + addend;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            step_reg <= '0;
        end else begin
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk) begin
        acc_reg <= acc_next;
    end

    assign done = (step_reg == 3'd4);
    assign hash = acc_reg ^ (acc_reg >> 16);

endmodule
`default_nettype wire

### rtl/cuckoo_session_sequence_tracker_top.sv
`default_nettype none
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tuser: mode; s_tdata: key_hash, key_fingerprint,
//                                   session_count
// m_*       out  m_tvalid/m_tready  m_tdata: status, found, entry_count
//
// One transfer in gives one transfer out. Items are worked one at a time.
// Query/delete/plain add pass through accept, hash, two bucket reads, evaluate and
// result load; rejected adds and zero fingerprints go from accept to result load.
// Each cuckoo kick adds a swap write, a hash of the evicted entry, a read and an evaluate.
// Clear sweeps the bucket memory one row a cycle, over every bucket. The same
// sweep runs after reset; s_tready stays low until it ends.
// A finished result waits in the output register; the next item is taken meanwhile.
module cuckoo_session_sequence_tracker_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // key_hash[31:0], key_fingerprint[47:32],
                                        // session_count[63:48]
    input  wire logic [1:0]  s_tuser,   // mode[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // status[2:0], found[3], entry_count[16:4]
);

    localparam int BB = csst_pkg::BUCKET_BITS;
    localparam int SB = csst_pkg::SLOT_BITS;
    localparam int KB = csst_pkg::KICK_BITS;

    // bucket memory: one row holds all slots of a bucket
    csst_pkg::row_t mem [csst_pkg::BUCKET_COUNT];
    csst_pkg::row_t mem_q;
    logic           mem_we, mem_re;
    logic [BB-1:0]  mem_wa, mem_ra;
    csst_pkg::row_t mem_wd;

    always_ff @(posedge clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            mem_q <= mem[mem_ra];
        end
    end

    csst_pkg::state_t  state_reg, state_next;
    csst_pkg::mode_t   mode_reg, mode_next;
    logic [BB-1:0]     i1_reg, i1_next, i2_reg, i2_next, cur_reg, cur_next;
    logic [15:0]       fp_reg, fp_next;
    logic [7:0]        cnt_reg, cnt_next;
    csst_pkg::row_t    row1_reg, row1_next, crow_reg, crow_next;
    csst_pkg::slot_t   ev_reg, ev_next;
    logic [KB-1:0]     kick_reg, kick_next;
    logic [15:0]       lfsr_reg, lfsr_next;
    logic [12:0]       count_reg, count_next;
    csst_pkg::status_t status_reg, status_next;
    logic              found_reg, found_next;
    logic [BB-1:0]     clr_reg, clr_next;
    logic              clr_resp_reg, clr_resp_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [23:0]       m_tdata_reg, m_tdata_next;

    logic              h_start, h_done;
    logic [15:0]       h_fp;
    logic [31:0]       h_val;
    logic [BB-1:0]     h_bits;

    csst_fp_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (h_start),
        .fp    (h_fp),
        .done  (h_done),
        .hash  (h_val)
    );

    assign h_bits = h_val[31 -: BB];

    csst_pkg::hit_t    m1, m2, e1, e2, mk, ek;
    csst_pkg::merge_t  mg1, mg2, mgk;
    csst_pkg::row_t    row2, rowk, wrow;
    csst_pkg::slot_t   newslot;
    logic [15:0]       lfsr_adv;
    logic [SB-1:0]     vslot;
    logic [12:0]       count_inc, count_dec;

    assign row2 = mem_q;
    assign rowk = mem_q;
    assign m1 = csst_pkg::find_fp(row1_reg, fp_reg);
    assign m2 = csst_pkg::find_fp(row2, fp_reg);
    assign e1 = csst_pkg::find_fp(row1_reg, 16'd0);
    assign e2 = csst_pkg::find_fp(row2, 16'd0);
    assign mk = csst_pkg::find_fp(rowk, ev_reg.fp);
    assign ek = csst_pkg::find_fp(rowk, 16'd0);
    assign mg1 = csst_pkg::merge_fn(row1_reg[m1.idx], cnt_reg);
    assign mg2 = csst_pkg::merge_fn(row2[m2.idx], cnt_reg);
    assign mgk = csst_pkg::merge_fn(rowk[mk.idx], ev_reg.lc);
    assign newslot = '{mask: 8'd0, lc: cnt_reg, fp: fp_reg};
    assign lfsr_adv = csst_pkg::lfsr_step(lfsr_reg);
    assign vslot = lfsr_adv[SB-1:0];
    assign count_inc = (count_reg < csst_pkg::COUNT_MAX) ? count_reg + 13'd1 : count_reg;
    assign count_dec = (count_reg != 13'd0) ? count_reg - 13'd1 : count_reg;

    always_comb begin
        state_next = state_reg;
        mode_next = mode_reg;
        i1_next = i1_reg;
        i2_next = i2_reg;
        cur_next = cur_reg;
        fp_next = fp_reg;
        cnt_next = cnt_reg;
        row1_next = row1_reg;
        crow_next = crow_reg;
        ev_next = ev_reg;
        kick_next = kick_reg;
        lfsr_next = lfsr_reg;
        count_next = count_reg;
        status_next = status_reg;
        found_next = found_reg;
        clr_next = clr_reg;
        clr_resp_next = clr_resp_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next = m_tdata_reg;
        s_tready = 1'b0;
        mem_we = 1'b0;
        mem_wa = cur_reg;
        mem_wd = '0;
        mem_re = 1'b0;
        mem_ra = i1_reg;
        h_start = 1'b0;
        h_fp = s_tdata[47:32];
        wrow = crow_reg;

        unique case (state_reg)
            csst_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    mode_next = csst_pkg::mode_t'(s_tuser);
                    i1_next = s_tdata[BB-1:0];
                    fp_next = s_tdata[47:32];
                    cnt_next = s_tdata[55:48];
                    status_next = csst_pkg::STAT_ADDED;
                    found_next = 1'b0;
                    state_next = csst_pkg::S_DONE;
                    if (s_tuser == csst_pkg::MODE_CLEAR) begin
                        clr_next = '0;
                        clr_resp_next = 1'b1;
                        state_next = csst_pkg::S_CLEAR;
                    end else if (s_tuser == csst_pkg::MODE_ADD && s_tdata[63:56] != 8'd0) begin
                        status_next = csst_pkg::STAT_CNT_BIG;
                    end else if (s_tdata[47:32] == 16'd0) begin
                        if (s_tuser == csst_pkg::MODE_ADD) begin
                            status_next = csst_pkg::STAT_FULL;
                        end
                    end else begin
                        h_start = 1'b1;
                        state_next = csst_pkg::S_HASH;
                    end
                end
            end
            csst_pkg::S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == BB'(csst_pkg::BUCKET_COUNT - 1)) begin
                    count_next = '0;
                    state_next = clr_resp_reg ? csst_pkg::S_DONE : csst_pkg::S_IDLE;
                end
            end
            csst_pkg::S_HASH: begin
                if (h_done) begin
                    i2_next = i1_reg ^ h_bits;
                    state_next = csst_pkg::S_RD1;
                end
            end
            csst_pkg::S_RD1: begin
                mem_re = 1'b1;
                mem_ra = i1_reg;
                state_next = csst_pkg::S_RD2;
            end
            csst_pkg::S_RD2: begin
                row1_next = mem_q;
                mem_re = 1'b1;
                mem_ra = i2_reg;
                state_next = csst_pkg::S_EVAL;
            end
            csst_pkg::S_EVAL: begin
                state_next = csst_pkg::S_DONE;
                unique case (mode_reg)
                    csst_pkg::MODE_QUERY: begin
                        found_next = m1.hit || m2.hit;
                    end
                    csst_pkg::MODE_DELETE: begin
                        if (m1.hit) begin
                            wrow = row1_reg;
                            wrow[m1.idx] = '0;
                            mem_we = 1'b1;
                            mem_wa = i1_reg;
                            mem_wd = wrow;
                        end else if (m2.hit) begin
                            wrow = row2;
                            wrow[m2.idx] = '0;
                            mem_we = 1'b1;
                            mem_wa = i2_reg;
                            mem_wd = wrow;
                        end
                        if (m1.hit || m2.hit) begin
                            found_next = 1'b1;
                            count_next = count_dec;
                        end
                    end
                    csst_pkg::MODE_ADD: begin
                        if (m1.hit) begin
                            wrow = row1_reg;
                            wrow[m1.idx] = mg1.slot;
                            mem_we = 1'b1;
                            mem_wa = i1_reg;
                            mem_wd = wrow;
                            status_next = mg1.status;
                        end else if (m2.hit) begin
                            wrow = row2;
                            wrow[m2.idx] = mg2.slot;
                            mem_we = 1'b1;
                            mem_wa = i2_reg;
                            mem_wd = wrow;
                            status_next = mg2.status;
                        end else if (e1.hit) begin
                            wrow = row1_reg;
                            wrow[e1.idx] = newslot;
                            mem_we = 1'b1;
                            mem_wa = i1_reg;
                            mem_wd = wrow;
                            count_next = count_inc;
                        end else if (e2.hit) begin
                            wrow = row2;
                            wrow[e2.idx] = newslot;
                            mem_we = 1'b1;
                            mem_wa = i2_reg;
                            mem_wd = wrow;
                            count_next = count_inc;
                        end else begin
                            // both buckets full: start relocating
                            lfsr_next = lfsr_adv;
                            cur_next = lfsr_adv[0] ? i1_reg : i2_reg;
                            crow_next = lfsr_adv[0] ? row1_reg : row2;
                            ev_next = newslot;
                            kick_next = '0;
                            state_next = csst_pkg::S_SWAP;
                        end
                    end
                    default: begin
                        state_next = csst_pkg::S_DONE;
                    end
                endcase
            end
            csst_pkg::S_SWAP: begin
                lfsr_next = lfsr_adv;
                wrow = crow_reg;
                wrow[vslot] = ev_reg;
                mem_we = 1'b1;
                mem_wa = cur_reg;
                mem_wd = wrow;
                ev_next = crow_reg[vslot];
                h_start = 1'b1;
                h_fp = crow_reg[vslot].fp;
                state_next = csst_pkg::S_KHASH;
            end
            csst_pkg::S_KHASH: begin
                if (h_done) begin
                    cur_next = cur_reg ^ h_bits;
                    state_next = csst_pkg::S_KRD;
                end
            end
            csst_pkg::S_KRD: begin
                mem_re = 1'b1;
                mem_ra = cur_reg;
                state_next = csst_pkg::S_KEVAL;
            end
            csst_pkg::S_KEVAL: begin
                state_next = csst_pkg::S_DONE;
                if (mk.hit) begin
                    wrow = rowk;
                    wrow[mk.idx] = mgk.slot;
                    mem_we = 1'b1;
                    mem_wa = cur_reg;
                    mem_wd = wrow;
                    status_next = mgk.status;
                end else if (ek.hit) begin
                    wrow = rowk;
                    wrow[ek.idx] = ev_reg;
                    mem_we = 1'b1;
                    mem_wa = cur_reg;
                    mem_wd = wrow;
                    count_next = count_inc;
                end else if (kick_reg == KB'(csst_pkg::MAX_KICKS - 1)) begin
                    // evicted entry is dropped, count unchanged
                    status_next = csst_pkg::STAT_FULL;
                end else begin
                    kick_next = kick_reg + 1'b1;
                    crow_next = rowk;
                    state_next = csst_pkg::S_SWAP;
                end
            end
            csst_pkg::S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next = {7'd0, count_reg, found_reg, status_reg};
                    state_next = csst_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = csst_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= csst_pkg::S_CLEAR;
            clr_reg <= '0;
            clr_resp_reg <= 1'b0;
            lfsr_reg <= csst_pkg::LFSR_SEED;
            count_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            clr_resp_reg <= clr_resp_next;
            lfsr_reg <= lfsr_next;
            count_reg <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk) begin
        mode_reg <= mode_next;
        i1_reg <= i1_next;
        i2_reg <= i2_next;
        cur_reg <= cur_next;
        fp_reg <= fp_next;
        cnt_reg <= cnt_next;
        row1_reg <= row1_next;
        crow_reg <= crow_next;
        ev_reg <= ev_next;
        kick_reg <= kick_next;
        status_reg <= status_next;
        found_reg <= found_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;

endmodule
`default_nettype wire
